/* src/imh_pkg.sv */
// Shared types and constants for the indexed min-heap.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
    localparam int CAPACITY = 256;
    localparam int KEY_W    = 8;
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ENT_W    = KEY_W + VAL_W;
    localparam int KEYS     = 1 << KEY_W;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_UPDATE  = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;
endpackage
`default_nettype wire

/* src/imh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

/* src/indexed_min_heap.sv */
// Indexed binary min-heap top level: sequencer over the slot store and key table.
//
//  channel | direction | tuser            | tdata (low bit up)
//  s_      | in        | action [1:0]     | item_key [7:0], item_value [39:8]
//  m_      | out       | status [1:0]     | out_key [7:0], out_value [39:8],
//          |           |                  | entry_count [48:40]
//
// One item at a time; a sift up passes S_UP and S_UPCMP per level, a sift down
// S_DN, S_DNL, S_DNR when a right child exists, and S_DNMV, all through the single
// read port of the slot RAM. Key lookup passes S_KS and S_KEY, an extract S_EX0 and
// S_EX1 before its sift down. Worst case: a present key inserted at the root, sifting down.
// Reset clears count and control; RAM contents are not cleared.
// A result waits in the output register while the next transfer is taken.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [1:0]                    s_tuser,  // action
    input  wire logic [imh_pkg::S_DATA_W-1:0]  s_tdata,  // item_key, item_value
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [1:0]                         m_tuser,  // status
    output logic [imh_pkg::M_DATA_W-1:0]       m_tdata   // out_key, out_value, entry_count
);
    import imh_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_KS    = 13'b0000000000010,
        S_KEY   = 13'b0000000000100,
        S_ABS   = 13'b0000000001000,
        S_UP    = 13'b0000000010000,
        S_UPCMP = 13'b0000000100000,
        S_DN    = 13'b0000001000000,
        S_DNL   = 13'b0000010000000,
        S_DNR   = 13'b0000100000000,
        S_DNMV  = 13'b0001000000000,
        S_EX0   = 13'b0010000000000,
        S_EX1   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    action_t act_reg, act_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [KEY_W-1:0] cur_key_reg, cur_key_next;
    logic signed [VAL_W-1:0] cur_val_reg, cur_val_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic dn_after_reg, dn_after_next;
    logic [KEY_W-1:0] bkey_reg, bkey_next;
    logic signed [VAL_W-1:0] bval_reg, bval_next;
    logic [SLOT_W-1:0] bidx_reg, bidx_next;
    logic bchild_reg, bchild_next;
    status_t res_st_reg, res_st_next;
    logic [KEY_W-1:0] res_key_reg, res_key_next;
    logic [VAL_W-1:0] res_val_reg, res_val_next;
    logic m_valid_reg, m_valid_next;
    logic [1:0] m_user_reg, m_user_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic s_wr_en, k_wr_en;
    logic [SLOT_W-1:0] s_wr_addr, s_rd_addr, k_wr_data;
    logic [KEY_W-1:0] k_wr_addr, k_rd_addr;
    logic [ENT_W-1:0] s_wr_data, s_rd_data;
    logic [SLOT_W-1:0] k_rd_data;

    logic [KEY_W-1:0] rd_key;
    logic signed [VAL_W-1:0] rd_val;
    logic [CNT_W-1:0] lidx, ridx;
    logic [SLOT_W-1:0] pidx;

    imh_ram #(.WIDTH(ENT_W), .DEPTH(CAPACITY)) u_slot_ram (
        .aclk(aclk), .wr_en(s_wr_en), .wr_addr(s_wr_addr), .wr_data(s_wr_data),
        .rd_addr(s_rd_addr), .rd_data(s_rd_data)
    );

    imh_ram #(.WIDTH(SLOT_W), .DEPTH(KEYS)) u_key_ram (
        .aclk(aclk), .wr_en(k_wr_en), .wr_addr(k_wr_addr), .wr_data(k_wr_data),
        .rd_addr(k_rd_addr), .rd_data(k_rd_data)
    );

    assign rd_key = s_rd_data[ENT_W-1:VAL_W];
    assign rd_val = $signed(s_rd_data[VAL_W-1:0]);
    assign lidx = {idx_reg, 1'b1};
    assign ridx = lidx + 1'b1;
    assign pidx = SLOT_W'((idx_reg - 1'b1) >> 1);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        cur_key_next  = cur_key_reg;
        cur_val_next  = cur_val_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        dn_after_next = dn_after_reg;
        bkey_next     = bkey_reg;
        bval_next     = bval_reg;
        bidx_next     = bidx_reg;
        bchild_next   = bchild_reg;
        res_st_next   = res_st_reg;
        res_key_next  = res_key_reg;
        res_val_next  = res_val_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_user_next   = m_user_reg;
        m_data_next   = m_data_reg;
        s_wr_en   = 1'b0;
        s_wr_addr = idx_reg;
        s_wr_data = {cur_key_reg, cur_val_reg};
        s_rd_addr = idx_reg;
        k_wr_en   = 1'b0;
        k_wr_addr = cur_key_reg;
        k_wr_data = idx_reg;
        k_rd_addr = s_tdata[KEY_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    act_next     = action_t'(s_tuser);
                    key_next     = s_tdata[KEY_W-1:0];
                    val_next     = $signed(s_tdata[KEY_W+VAL_W-1:KEY_W]);
                    res_st_next  = ST_OK;
                    res_key_next = '0;
                    res_val_next = '0;
                    dn_after_next = 1'b0;
                    case (action_t'(s_tuser))
                        ACT_INSERT, ACT_UPDATE: state_next = S_KS;
                        ACT_EXTRACT: begin
                            s_rd_addr = '0;
                            if (count_reg == '0) begin
                                res_st_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_EX0;
                            end
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_KS: begin
                idx_next  = k_rd_data;
                s_rd_addr = k_rd_data;
                state_next = ({1'b0, k_rd_data} < count_reg) ? S_KEY : S_ABS;
            end
            S_KEY: begin
                if (rd_key == key_reg) begin
                    cur_key_next  = key_reg;
                    cur_val_next  = val_reg;
                    dn_after_next = (act_reg == ACT_INSERT);
                    state_next    = S_UP;
                end else begin
                    state_next = S_ABS;
                end
            end
            S_ABS: begin
                if (act_reg == ACT_UPDATE) begin
                    res_st_next = ST_MISSING;
                    state_next  = S_DONE;
                end else if (count_reg == CNT_W'(CAPACITY)) begin
                    res_st_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    cur_key_next = key_reg;
                    cur_val_next = val_reg;
                    idx_next     = count_reg[SLOT_W-1:0];
                    count_next   = count_reg + 1'b1;
                    state_next   = S_UP;
                end
            end
            S_UP: begin
                s_rd_addr = pidx;
                if (idx_reg == '0) begin
                    if (dn_after_reg) begin
                        state_next = S_DN;
                    end else begin
                        s_wr_en = 1'b1;
                        k_wr_en = 1'b1;
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (cur_val_reg < rd_val) begin
                    s_wr_en   = 1'b1;
                    s_wr_data = s_rd_data;
                    k_wr_en   = 1'b1;
                    k_wr_addr = rd_key;
                    idx_next  = pidx;
                    state_next = S_UP;
                end else if (dn_after_reg) begin
                    state_next = S_DN;
                end else begin
                    s_wr_en = 1'b1;
                    k_wr_en = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN: begin
                s_rd_addr = lidx[SLOT_W-1:0];
                if (lidx < count_reg) begin
                    state_next = S_DNL;
                end else begin
                    s_wr_en = 1'b1;
                    k_wr_en = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DNL: begin
                s_rd_addr = ridx[SLOT_W-1:0];
                if (rd_val < cur_val_reg) begin
                    bkey_next   = rd_key;
                    bval_next   = rd_val;
                    bidx_next   = lidx[SLOT_W-1:0];
                    bchild_next = 1'b1;
                end else begin
                    bval_next   = cur_val_reg;
                    bchild_next = 1'b0;
                end
                state_next = (ridx < count_reg) ? S_DNR : S_DNMV;
            end
            S_DNR: begin
                if (rd_val < bval_reg) begin
                    bkey_next   = rd_key;
                    bval_next   = rd_val;
                    bidx_next   = ridx[SLOT_W-1:0];
                    bchild_next = 1'b1;
                end
                state_next = S_DNMV;
            end
            S_DNMV: begin
                s_wr_en = 1'b1;
                k_wr_en = 1'b1;
                if (bchild_reg) begin
                    s_wr_data = {bkey_reg, bval_reg};
                    k_wr_addr = bkey_reg;
                    idx_next  = bidx_reg;
                    state_next = S_DN;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_EX0: begin
                res_key_next = rd_key;
                res_val_next = rd_val;
                count_next   = count_reg - 1'b1;
                s_rd_addr    = SLOT_W'(count_reg - 1'b1);
                state_next   = (count_reg == CNT_W'(1)) ? S_DONE : S_EX1;
            end
            S_EX1: begin
                cur_key_next = rd_key;
                cur_val_next = rd_val;
                idx_next     = '0;
                state_next   = S_DN;
            end
            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_user_next  = res_st_reg;
                    m_data_next  = M_DATA_W'({count_reg, res_val_reg, res_key_reg});
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg      <= act_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        cur_key_reg  <= cur_key_next;
        cur_val_reg  <= cur_val_next;
        idx_reg      <= idx_next;
        dn_after_reg <= dn_after_next;
        bkey_reg     <= bkey_next;
        bval_reg     <= bval_next;
        bidx_reg     <= bidx_next;
        bchild_reg   <= bchild_next;
        res_st_reg   <= res_st_next;
        res_key_reg  <= res_key_next;
        res_val_reg  <= res_val_next;
        m_user_reg   <= m_user_next;
        m_data_reg   <= m_data_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken while busy");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_st_reg == ST_FULL) |-> count_reg == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("count changed on accept");
endmodule
`default_nettype wire
